/* rtl/fbc_pkg.sv */
// shared types, constants and command codes of the flash backup command controller
`default_nettype none

package fbc_pkg;

   localparam int unsigned OFFSET_W = 16;
   localparam int unsigned DATA_W   = 8;
   localparam int unsigned STEP_W   = 3;

   // both sizes are powers of two
   localparam int unsigned STORE_BYTES_DEFAULT  = 65536;
   localparam int unsigned SECTOR_BYTES_DEFAULT = 4096;

   localparam logic [OFFSET_W-1:0] CMD_ADDR_A = 16'h5555;
   localparam logic [OFFSET_W-1:0] CMD_ADDR_B = 16'h2AAA;

   localparam logic [DATA_W-1:0] CODE_UNLOCK_A  = 8'hAA;
   localparam logic [DATA_W-1:0] CODE_UNLOCK_B  = 8'h55;
   localparam logic [DATA_W-1:0] CODE_ID_ENTER  = 8'h90;
   localparam logic [DATA_W-1:0] CODE_ID_EXIT   = 8'hF0;
   localparam logic [DATA_W-1:0] CODE_PROGRAM   = 8'hA0;
   localparam logic [DATA_W-1:0] CODE_ERASE     = 8'h80;
   localparam logic [DATA_W-1:0] CODE_ERASE_CHP = 8'h10;
   localparam logic [DATA_W-1:0] CODE_ERASE_SEC = 8'h30;

   localparam logic [DATA_W-1:0] ID_BYTE_0  = 8'hBF;
   localparam logic [DATA_W-1:0] ID_BYTE_1  = 8'hD4;
   localparam logic [DATA_W-1:0] ERASED_VAL = 8'hFF;

   localparam logic [OFFSET_W-1:0] ID_OFFSET_0 = 16'h0000;
   localparam logic [OFFSET_W-1:0] ID_OFFSET_1 = 16'h0001;

   localparam logic [STEP_W-1:0] STEP_NONE          = 3'd0;
   localparam logic [STEP_W-1:0] STEP_UNLOCK_B      = 3'd1;
   localparam logic [STEP_W-1:0] STEP_COMMAND       = 3'd2;
   localparam logic [STEP_W-1:0] STEP_ERASE_UNLK_A  = 3'd3;
   localparam logic [STEP_W-1:0] STEP_ERASE_UNLK_B  = 3'd4;
   localparam logic [STEP_W-1:0] STEP_ERASE_COMMAND = 3'd5;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FINISH,
      ST_ERASE,
      ST_RESP
   } state_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_READ,
      ACT_RAW,
      ACT_PROGRAM,
      ACT_ERASE_CHIP,
      ACT_ERASE_SECTOR
   } action_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_RAW,
      WR_PROG,
      WR_FILL
   } wr_op_type;

   typedef enum logic [1:0] {
      RD_MEM,
      RD_ID0,
      RD_ID1,
      RD_ZERO
   } rd_kind_type;

   typedef struct packed {
      logic              capture;
      logic              sweep_chip;
      wr_op_type         wr_op;
      logic              sweep_step;
      logic              load_rsp;
      rd_kind_type       rd_kind;
      logic [STEP_W-1:0] step;
      logic              id_mode;
   } ctrl_cmd_type;

   typedef struct packed {
      logic sweep_last;
      logic rsp_free;
   } dp_status_type;

endpackage

`default_nettype wire

/* rtl/fbc_if.sv */
// request and response channel interfaces of the flash backup command controller
`default_nettype none

interface fbc_req_if;
   import fbc_pkg::*;

   logic                valid;
   logic                ready;
   logic                req_type;
   logic [OFFSET_W-1:0] offset;
   logic [DATA_W-1:0]   write_data;

   modport source (output valid, output req_type, output offset, output write_data,
                   input ready);
   modport sink   (input valid, input req_type, input offset, input write_data,
                   output ready);
endinterface

interface fbc_rsp_if;
   import fbc_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] read_data;
   logic [STEP_W-1:0] command_step;
   logic              in_id_mode;

   modport source (output valid, output read_data, output command_step, output in_id_mode,
                   input ready);
   modport sink   (input valid, input read_data, input command_step, input in_id_mode,
                   output ready);
endinterface

`default_nettype wire

/* rtl/fbc_ctrl.sv */
// controller: flash command sequencer and transaction state machine
`default_nettype none

module fbc_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_write_enable,
   input  wire logic                    csr_write_data,
   input  wire logic                    req_valid,
   input  wire logic                    req_type,
   input  wire logic [fbc_pkg::OFFSET_W-1:0] req_offset,
   input  wire logic [fbc_pkg::DATA_W-1:0]   req_write_data,
   output logic                         req_ready,
   input  wire fbc_pkg::dp_status_type  status,
   output fbc_pkg::ctrl_cmd_type        cmd
);
   import fbc_pkg::*;

   state_type         state_ff, state_in;
   action_type        action_ff, action_in;
   logic              flash_ff, flash_in;
   logic              unlocked_ff, unlocked_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              id_ff, id_in;
   logic              prog_ff, prog_in;

   logic              accept;
   action_type        act;
   rd_kind_type       rd_kind;
   logic              seq_unlocked;
   logic [STEP_W-1:0] seq_step;
   logic              seq_id;
   logic              seq_prog;

   assign accept = req_valid && (state_ff == ST_IDLE);

   // decode of the accepted transaction against the command sequence
   always_comb begin
      logic clear_seq;
      clear_seq    = 1'b0;
      seq_unlocked = unlocked_ff;
      seq_step     = step_ff;
      seq_id       = id_ff;
      seq_prog     = prog_ff;
      act          = ACT_NONE;
      rd_kind      = RD_ZERO;
      if (!req_type) begin
         act = ACT_READ;
         if (flash_ff && id_ff && (req_offset == ID_OFFSET_0)) begin
            rd_kind = RD_ID0;
         end else if (flash_ff && id_ff && (req_offset == ID_OFFSET_1)) begin
            rd_kind = RD_ID1;
         end else begin
            rd_kind = RD_MEM;
         end
      end else if (!flash_ff) begin
         act = ACT_RAW;
      end else if (prog_ff) begin
         act      = ACT_PROGRAM;
         seq_prog = 1'b0;
      end else if (!unlocked_ff) begin
         if ((req_offset == CMD_ADDR_A) && (req_write_data == CODE_UNLOCK_A)) begin
            seq_unlocked = 1'b1;
            seq_step     = STEP_UNLOCK_B;
         end
      end else begin
         clear_seq = 1'b1;
         unique case (step_ff)
            STEP_UNLOCK_B: begin
               if ((req_offset == CMD_ADDR_B) && (req_write_data == CODE_UNLOCK_B)) begin
                  seq_step  = STEP_COMMAND;
                  clear_seq = 1'b0;
               end
            end
            STEP_COMMAND: begin
               if (req_offset == CMD_ADDR_A) begin
                  priority if (req_write_data == CODE_ID_ENTER) begin
                     clear_seq = 1'b0;
                     seq_id       = 1'b1;
                     seq_unlocked = 1'b0;
                     seq_step     = STEP_NONE;
                  end else if (req_write_data == CODE_ID_EXIT) begin
                     clear_seq = 1'b0;
                     seq_id       = 1'b0;
                     seq_unlocked = 1'b0;
                     seq_step     = STEP_NONE;
                  end else if (req_write_data == CODE_PROGRAM) begin
                     clear_seq = 1'b0;
                     seq_prog     = 1'b1;
                     seq_unlocked = 1'b0;
                     seq_step     = STEP_NONE;
                  end else if (req_write_data == CODE_ERASE) begin
                     clear_seq = 1'b0;
                     seq_step  = STEP_ERASE_UNLK_A;
                  end else begin
                     clear_seq = 1'b1;
                  end
               end
            end
            STEP_ERASE_UNLK_A: begin
               if ((req_offset == CMD_ADDR_A) && (req_write_data == CODE_UNLOCK_A)) begin
                  seq_step  = STEP_ERASE_UNLK_B;
                  clear_seq = 1'b0;
               end
            end
            STEP_ERASE_UNLK_B: begin
               if ((req_offset == CMD_ADDR_B) && (req_write_data == CODE_UNLOCK_B)) begin
                  seq_step  = STEP_ERASE_COMMAND;
                  clear_seq = 1'b0;
               end
            end
            STEP_ERASE_COMMAND: begin
               // the sequence ends here whether or not anything is erased
               if ((req_write_data == CODE_ERASE_CHP) && (req_offset == CMD_ADDR_A)) begin
                  act = ACT_ERASE_CHIP;
               end else if (req_write_data == CODE_ERASE_SEC) begin
                  act = ACT_ERASE_SECTOR;
               end
            end
            default: begin
               clear_seq = 1'b1;
            end
         endcase
         if (clear_seq) begin
            seq_unlocked = 1'b0;
            seq_step     = STEP_NONE;
            seq_id       = 1'b0;
            seq_prog     = 1'b0;
         end
      end
   end

   always_comb begin
      flash_in    = csr_write_enable ? csr_write_data : flash_ff;
      unlocked_in = accept ? seq_unlocked : unlocked_ff;
      step_in     = accept ? seq_step : step_ff;
      id_in       = accept ? seq_id : id_ff;
      prog_in     = accept ? seq_prog : prog_ff;
      action_in   = accept ? act : action_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               if ((act == ACT_ERASE_CHIP) || (act == ACT_ERASE_SECTOR)) begin
                  state_in = ST_ERASE;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            state_in = status.rsp_free ? ST_IDLE : ST_RESP;
         end
         ST_ERASE: begin
            if (status.sweep_last) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready      = (state_ff == ST_IDLE);
      cmd.capture    = accept;
      cmd.sweep_chip = (act == ACT_ERASE_CHIP);
      cmd.wr_op      = WR_NONE;
      cmd.sweep_step = 1'b0;
      cmd.load_rsp   = 1'b0;
      cmd.rd_kind    = rd_kind;
      cmd.step       = step_ff;
      cmd.id_mode    = id_ff;
      unique case (state_ff)
         ST_CLEAR, ST_ERASE: begin
            cmd.wr_op      = WR_FILL;
            cmd.sweep_step = 1'b1;
         end
         ST_FINISH: begin
            if (action_ff == ACT_RAW) begin
               cmd.wr_op = WR_RAW;
            end else if (action_ff == ACT_PROGRAM) begin
               cmd.wr_op = WR_PROG;
            end
            cmd.load_rsp = status.rsp_free;
         end
         ST_RESP: begin
            cmd.load_rsp = status.rsp_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         action_ff   <= ACT_NONE;
         flash_ff    <= 1'b0;
         unlocked_ff <= 1'b0;
         step_ff     <= STEP_NONE;
         id_ff       <= 1'b0;
         prog_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         action_ff   <= action_in;
         flash_ff    <= flash_in;
         unlocked_ff <= unlocked_in;
         step_ff     <= step_in;
         id_ff       <= id_in;
         prog_ff     <= prog_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/fbc_dpath.sv */
// datapath: backup store memory, erase sweep counter and response register
`default_nettype none

module fbc_dpath #(
   parameter int unsigned STORE_BYTES  = fbc_pkg::STORE_BYTES_DEFAULT,
   parameter int unsigned SECTOR_BYTES = fbc_pkg::SECTOR_BYTES_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [fbc_pkg::OFFSET_W-1:0] req_offset,
   input  wire logic [fbc_pkg::DATA_W-1:0]   req_write_data,
   input  wire fbc_pkg::ctrl_cmd_type        cmd,
   output fbc_pkg::dp_status_type            status,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [fbc_pkg::DATA_W-1:0]        rsp_read_data,
   output logic [fbc_pkg::STEP_W-1:0]        rsp_command_step,
   output logic                              rsp_in_id_mode
);
   import fbc_pkg::*;

   localparam int unsigned IDX_W    = $clog2(STORE_BYTES);
   localparam int unsigned SEC_SPAN = (SECTOR_BYTES < STORE_BYTES) ? SECTOR_BYTES : STORE_BYTES;
   localparam logic [IDX_W-1:0] SECTOR_MASK = IDX_W'(SEC_SPAN - 1);

   logic [DATA_W-1:0] store_ff [STORE_BYTES];

   logic [IDX_W-1:0]  idx_ff;
   logic [DATA_W-1:0] wdata_ff;
   logic [DATA_W-1:0] rdata_ff;
   rd_kind_type       rd_kind_ff;
   logic [IDX_W-1:0]  mask_ff, mask_in;
   logic [IDX_W-1:0]  cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff;
   logic [STEP_W-1:0] rsp_step_ff;
   logic              rsp_id_ff;

   logic [IDX_W-1:0]  req_idx;
   logic [IDX_W-1:0]  sweep_addr;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic [DATA_W-1:0] mem_wdata;
   logic [DATA_W-1:0] rd_value;

   // offsets wrap at the store size
   assign req_idx    = req_offset[IDX_W-1:0];
   assign sweep_addr = (idx_ff & ~mask_ff) | (cnt_ff & mask_ff);

   assign status.sweep_last = ((cnt_ff & mask_ff) == mask_ff);
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = idx_ff;
      mem_wdata = wdata_ff;
      unique case (cmd.wr_op)
         WR_RAW: begin
            mem_we = 1'b1;
         end
         WR_PROG: begin
            mem_we    = 1'b1;
            mem_wdata = rdata_ff & wdata_ff;
         end
         WR_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_addr;
            mem_wdata = ERASED_VAL;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      unique case (rd_kind_ff)
         RD_MEM:  rd_value = rdata_ff;
         RD_ID0:  rd_value = ID_BYTE_0;
         RD_ID1:  rd_value = ID_BYTE_1;
         default: rd_value = '0;
      endcase
   end

   always_comb begin
      mask_in = mask_ff;
      cnt_in  = cnt_ff;
      if (cmd.capture) begin
         mask_in = cmd.sweep_chip ? '1 : SECTOR_MASK;
         cnt_in  = '0;
      end else if (cmd.sweep_step) begin
         cnt_in = IDX_W'(cnt_ff + 1'b1);
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) store_ff[mem_waddr] <= mem_wdata;
   end

   // the read is taken at the accept edge and held for the rest of the transaction
   always_ff @(posedge clock) begin
      if (cmd.capture) rdata_ff <= store_ff[req_idx];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         idx_ff     <= req_idx;
         wdata_ff   <= req_write_data;
         rd_kind_ff <= cmd.rd_kind;
      end
      if (cmd.load_rsp) begin
         rsp_data_ff <= rd_value;
         rsp_step_ff <= cmd.step;
         rsp_id_ff   <= cmd.id_mode;
      end
   end

   // reset starts a full clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '1;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = rsp_data_ff;
   assign rsp_command_step = rsp_step_ff;
   assign rsp_in_id_mode   = rsp_id_ff;

endmodule

`default_nettype wire

/* rtl/flash_backup_command_controller.sv */
// top level of the flash backup command controller
// Byte reads and writes into a backup store, with an optional flash command mode.
// req channel: one transaction per byte access (req_type 0 read, 1 write, offset,
// write_data); accepted when valid and ready are both high.
// rsp channel: one transaction per request with read_data, command_step and
// in_id_mode as they stand after the access.
// csr port: csr_write_enable writes csr_write_data into flash_enable; write it only
// while no request is in flight.
// Reads, raw writes, command bytes and programs pass through the accept cycle
// with its registered memory read, then the finish state for the write-back of
// the single store port and the load of the response register, once it is free.
// Erases fill the sector of the offset (sector) or the whole store (chip) with 0xFF,
// one store byte filled per cycle, then load the response.
// After reset the block clears the store to 0xFF and holds req ready low
// meanwhile; csr writes are taken throughout.
// A stalled rsp receiver holds the result in the output register; the block
// finishes the current transaction and then waits before taking the next.
`default_nettype none

module flash_backup_command_controller #(
   parameter int unsigned STORE_BYTES  = fbc_pkg::STORE_BYTES_DEFAULT,
   parameter int unsigned SECTOR_BYTES = fbc_pkg::SECTOR_BYTES_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  csr_write_enable,
   input  wire logic  csr_write_data,
   fbc_req_if.sink    req,
   fbc_rsp_if.source  rsp
);
   import fbc_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic          req_ready;

   assign req.ready = req_ready;

   fbc_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req.valid),
      .req_type         (req.req_type),
      .req_offset       (req.offset),
      .req_write_data   (req.write_data),
      .req_ready        (req_ready),
      .status           (status),
      .cmd              (cmd)
   );

   fbc_dpath #(
      .STORE_BYTES  (STORE_BYTES),
      .SECTOR_BYTES (SECTOR_BYTES)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_offset       (req.offset),
      .req_write_data   (req.write_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp.valid),
      .rsp_ready        (rsp.ready),
      .rsp_read_data    (rsp.read_data),
      .rsp_command_step (rsp.command_step),
      .rsp_in_id_mode   (rsp.in_id_mode)
   );

endmodule

`default_nettype wire

/* verif/flash_backup_command_controller_tb.sv */
// testbench for the flash backup command controller: byte accesses and flash commands checked
module flash_backup_command_controller_tb;
   import fbc_pkg::*;

   localparam int unsigned STORE_BYTES    = STORE_BYTES_DEFAULT;
   localparam int unsigned SECTOR_BYTES   = SECTOR_BYTES_DEFAULT;
   localparam int unsigned IDX_W          = $clog2(STORE_BYTES);
   localparam int unsigned RANDOM_ITEMS   = 1300;
   localparam int unsigned RANDOM_PHASES  = 10;
   localparam int unsigned SHOWN_FAILURES = 10;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic [STEP_W-1:0] command_step;
      logic              in_id_mode;
   } access_result_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic csr_write_data;

   fbc_req_if req_ch();
   fbc_rsp_if rsp_ch();

   flash_backup_command_controller dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req              (req_ch),
      .rsp              (rsp_ch)
   );

   // shadow of the backup store and the command machine
   logic [DATA_W-1:0] save_bytes [STORE_BYTES];
   logic              flash_on;
   logic              seq_open;
   logic [STEP_W-1:0] seq_step;
   logic              id_active;
   logic              prog_armed;

   access_result_type   awaited_responses [$];
   int                  failures = 0;
   int                  responses_seen = 0;
   int                  items_sent = 0;
   bit                  steady = 1'b0;
   logic [OFFSET_W-1:0] hot_offsets [16];

   always #6 clock = ~clock;

   function automatic void fill_erased(int unsigned base, int unsigned count);
      for (int unsigned i = base; i < base + count && i < STORE_BYTES; i++)
         save_bytes[IDX_W'(i)] = ERASED_VAL;
   endfunction

   function automatic void clear_sequence_state();
      seq_open   = 1'b0;
      seq_step   = STEP_NONE;
      id_active  = 1'b0;
      prog_armed = 1'b0;
   endfunction

   function automatic void flash_command(logic [OFFSET_W-1:0] off, logic [DATA_W-1:0] data);
      int unsigned idx;
      idx = off % STORE_BYTES;
      if (prog_armed) begin
         save_bytes[IDX_W'(idx)] = save_bytes[IDX_W'(idx)] & data;
         prog_armed = 1'b0;
         return;
      end
      // while locked only the first unlock write does anything
      if (!seq_open) begin
         if (off == CMD_ADDR_A && data == CODE_UNLOCK_A) begin
            seq_open = 1'b1;
            seq_step = STEP_UNLOCK_B;
         end
         return;
      end
      case (seq_step)
         STEP_UNLOCK_B: begin
            if (off == CMD_ADDR_B && data == CODE_UNLOCK_B) begin
               seq_step = STEP_COMMAND;
               return;
            end
         end
         STEP_COMMAND: begin
            if (off == CMD_ADDR_A) begin
               if (data == CODE_ID_ENTER) begin
                  id_active = 1'b1;
                  seq_open  = 1'b0;
                  seq_step  = STEP_NONE;
                  return;
               end
               if (data == CODE_ID_EXIT) begin
                  id_active = 1'b0;
                  seq_open  = 1'b0;
                  seq_step  = STEP_NONE;
                  return;
               end
               if (data == CODE_PROGRAM) begin
                  prog_armed = 1'b1;
                  seq_open   = 1'b0;
                  seq_step   = STEP_NONE;
                  return;
               end
               if (data == CODE_ERASE) begin
                  seq_step = STEP_ERASE_UNLK_A;
                  return;
               end
            end
         end
         STEP_ERASE_UNLK_A: begin
            if (off == CMD_ADDR_A && data == CODE_UNLOCK_A) begin
               seq_step = STEP_ERASE_UNLK_B;
               return;
            end
         end
         STEP_ERASE_UNLK_B: begin
            if (off == CMD_ADDR_B && data == CODE_UNLOCK_B) begin
               seq_step = STEP_ERASE_COMMAND;
               return;
            end
         end
         STEP_ERASE_COMMAND: begin
            if (data == CODE_ERASE_CHP && off == CMD_ADDR_A)
               fill_erased(0, STORE_BYTES);
            else if (data == CODE_ERASE_SEC)
               fill_erased(idx - idx % SECTOR_BYTES, SECTOR_BYTES);
         end
         default: ;
      endcase
      clear_sequence_state();
   endfunction

   function automatic access_result_type predict_access(logic is_write, logic [OFFSET_W-1:0] off,
                                                        logic [DATA_W-1:0] data);
      access_result_type r;
      r.read_data = '0;
      if (!is_write) begin
         if (flash_on && id_active && off == ID_OFFSET_0)
            r.read_data = ID_BYTE_0;
         else if (flash_on && id_active && off == ID_OFFSET_1)
            r.read_data = ID_BYTE_1;
         else
            r.read_data = save_bytes[IDX_W'(off % STORE_BYTES)];
      end else if (!flash_on) begin
         save_bytes[IDX_W'(off % STORE_BYTES)] = data;
      end else begin
         flash_command(off, data);
      end
      r.command_step = seq_step;
      r.in_id_mode   = id_active;
      return r;
   endfunction

   function automatic logic [OFFSET_W-1:0] pick_offset();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 4)
         return hot_offsets[4'($urandom_range(0, 15))];
      if (roll == 4)
         return $urandom_range(0, 1) ? ID_OFFSET_1 : ID_OFFSET_0;
      return OFFSET_W'($urandom_range(0, STORE_BYTES - 1));
   endfunction

   // one transaction on the request channel, valid stays high afterwards
   task automatic send_access(input logic is_write, input logic [OFFSET_W-1:0] off,
                              input logic [DATA_W-1:0] data);
      int                gap;
      access_result_type predicted;
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.req_type   <= is_write;
      req_ch.offset     <= off;
      req_ch.write_data <= data;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      predicted = predict_access(is_write, off, data);
      awaited_responses = {awaited_responses, predicted};
      items_sent++;
   endtask

   task automatic write_byte(input logic [OFFSET_W-1:0] off, input logic [DATA_W-1:0] data);
      send_access(1'b1, off, data);
   endtask

   task automatic read_byte(input logic [OFFSET_W-1:0] off);
      send_access(1'b0, off, DATA_W'($urandom_range(0, 255)));
   endtask

   task automatic unlock_seq();
      write_byte(CMD_ADDR_A, CODE_UNLOCK_A);
      write_byte(CMD_ADDR_B, CODE_UNLOCK_B);
   endtask

   task automatic issue_command(input logic [DATA_W-1:0] code);
      unlock_seq();
      write_byte(CMD_ADDR_A, code);
   endtask

   task automatic erase_sequence(input logic [OFFSET_W-1:0] off, input logic [DATA_W-1:0] code);
      issue_command(CODE_ERASE);
      unlock_seq();
      write_byte(off, code);
   endtask

   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      while (awaited_responses.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_flash_mode(input logic mode);
      drain_responses();
      csr_write_enable <= 1'b1;
      csr_write_data   <= mode;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      flash_on = mode;
   endtask

   task automatic test_plain_access();
      set_flash_mode(1'b0);
      write_byte(16'h0000, 8'h00);
      write_byte(16'hFFFF, 8'hFF);
      write_byte(16'h1234, 8'hA5);
      // unlock pattern stored as data, command state untouched
      write_byte(CMD_ADDR_A, CODE_UNLOCK_A);
      read_byte(16'h0000);
      read_byte(16'hFFFF);
      read_byte(16'h1234);
      read_byte(CMD_ADDR_A);
      read_byte(16'h8000);
   endtask

   task automatic test_id_mode();
      set_flash_mode(1'b1);
      issue_command(CODE_ID_ENTER);
      read_byte(ID_OFFSET_0);
      read_byte(ID_OFFSET_1);
      read_byte(16'h0002);
      // id bit kept in plain mode but store bytes returned
      set_flash_mode(1'b0);
      read_byte(ID_OFFSET_0);
      set_flash_mode(1'b1);
      issue_command(CODE_ID_EXIT);
      read_byte(ID_OFFSET_0);
   endtask

   task automatic test_program();
      issue_command(CODE_PROGRAM);
      write_byte(16'h1234, 8'h0F);
      read_byte(16'h1234);
      issue_command(CODE_PROGRAM);
      write_byte(16'hFFFF, 8'h00);
      read_byte(16'hFFFF);
   endtask

   task automatic test_broken_sequence();
      write_byte(CMD_ADDR_A, CODE_UNLOCK_A);
      write_byte(CMD_ADDR_B ^ 16'h0001, CODE_UNLOCK_B);
      write_byte(16'h1234, 8'h00);
      read_byte(16'h1234);
      issue_command(CODE_ID_ENTER);
      unlock_seq();
      // unknown command byte also drops id mode
      write_byte(CMD_ADDR_A, 8'h77);
      read_byte(ID_OFFSET_0);
   endtask

   task automatic test_erase();
      erase_sequence(16'h1ABC, CODE_ERASE_SEC);
      read_byte(16'h1234);
      read_byte(16'h0000);
      erase_sequence(16'h0000, CODE_ERASE_CHP);
      read_byte(16'h0000);
      erase_sequence(CMD_ADDR_A, 8'h42);
      read_byte(16'hFFFF);
      erase_sequence(CMD_ADDR_A, CODE_ERASE_CHP);
      read_byte(16'h0000);
      read_byte(16'hFFFF);
   endtask

   task automatic test_random_traffic();
      int                  phase_end;
      int                  roll;
      int                  kind;
      int                  n;
      int                  break_at;
      int                  sector_erases_left;
      int                  chip_erases_left;
      logic [OFFSET_W-1:0] seq_off [8];
      logic [DATA_W-1:0]   seq_dat [8];
      sector_erases_left = 40;
      chip_erases_left   = 1;
      hot_offsets[0] = ID_OFFSET_0;
      hot_offsets[1] = CMD_ADDR_A;
      hot_offsets[2] = CMD_ADDR_B;
      hot_offsets[3] = 16'hFFFF;
      for (int i = 4; i < 16; i++)
         hot_offsets[4'(i)] = 16'h3000 + OFFSET_W'($urandom_range(0, 16'h1FFF));
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         set_flash_mode(phase % 3 != 1);
         steady    = (phase == 2 || phase == 6);
         phase_end = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
         while (items_sent < phase_end) begin
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
               drain_responses();
            end else if (!flash_on) begin
               if (roll < 50)
                  read_byte(pick_offset());
               else
                  write_byte(pick_offset(), DATA_W'($urandom_range(0, 255)));
            end else if (roll < 25) begin
               read_byte(pick_offset());
            end else if (roll < 35) begin
               write_byte(roll < 30 ? ($urandom_range(0, 1) ? CMD_ADDR_A : CMD_ADDR_B)
                                    : pick_offset(),
                          $urandom_range(0, 1) ? DATA_W'($urandom_range(0, 255))
                                               : ($urandom_range(0, 1) ? CODE_UNLOCK_A
                                                                       : CODE_UNLOCK_B));
            end else if (roll < 95) begin
               kind = $urandom_range(0, 9);
               seq_off[0] = CMD_ADDR_A;
               seq_dat[0] = CODE_UNLOCK_A;
               seq_off[1] = CMD_ADDR_B;
               seq_dat[1] = CODE_UNLOCK_B;
               seq_off[2] = CMD_ADDR_A;
               n = 3;
               if (kind <= 2) begin
                  seq_dat[2] = CODE_ID_ENTER;
               end else if (kind <= 4) begin
                  seq_dat[2] = CODE_ID_EXIT;
               end else if (kind <= 7) begin
                  seq_dat[2] = CODE_PROGRAM;
                  seq_off[3] = pick_offset();
                  seq_dat[3] = DATA_W'($urandom_range(0, 255));
                  n = 4;
               end else begin
                  seq_dat[2] = CODE_ERASE;
                  seq_off[3] = CMD_ADDR_A;
                  seq_dat[3] = CODE_UNLOCK_A;
                  seq_off[4] = CMD_ADDR_B;
                  seq_dat[4] = CODE_UNLOCK_B;
                  n = 6;
                  // erases are long, so their number is bounded
                  if (sector_erases_left > 0 && $urandom_range(0, 7) != 0) begin
                     seq_off[5] = pick_offset();
                     seq_dat[5] = CODE_ERASE_SEC;
                     sector_erases_left--;
                  end else if (chip_erases_left > 0) begin
                     seq_off[5] = CMD_ADDR_A;
                     seq_dat[5] = CODE_ERASE_CHP;
                     chip_erases_left--;
                  end else begin
                     seq_off[5] = pick_offset();
                     seq_dat[5] = DATA_W'($urandom_range(0, 255));
                     if (seq_dat[5] == CODE_ERASE_CHP || seq_dat[5] == CODE_ERASE_SEC)
                        seq_dat[5] = seq_dat[5] ^ 8'h01;
                  end
               end
               // the last byte is never corrupted so a broken erase cannot turn into one
               break_at = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, n - 2)) : -1;
               for (int i = 0; i < n; i++) begin
                  if (i == break_at) begin
                     if ($urandom_range(0, 1))
                        seq_dat[3'(i)] = seq_dat[3'(i)] ^ (8'd1 << $urandom_range(0, 7));
                     else
                        seq_off[3'(i)] = seq_off[3'(i)] ^ (16'd1 << $urandom_range(0, 15));
                  end
                  write_byte(seq_off[3'(i)], seq_dat[3'(i)]);
               end
               if (n == 4 && $urandom_range(0, 1))
                  read_byte(seq_off[3]);
            end else begin
               read_byte($urandom_range(0, 1) ? ID_OFFSET_1 : ID_OFFSET_0);
            end
         end
      end
      steady = 1'b0;
   endtask

   // response side: random stalls, each transaction checked against the oldest prediction
   initial begin : response_monitor
      int                stall;
      access_result_type got;
      access_result_type want;
      rsp_ch.ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
         got = {rsp_ch.read_data, rsp_ch.command_step, rsp_ch.in_id_mode};
         responses_seen++;
         if (awaited_responses.size() == 0) begin
            failures++;
            if (failures <= SHOWN_FAILURES)
               $display("response %0d arrived with none outstanding: data %02h step %0d id %0b",
                        responses_seen, got.read_data, got.command_step, got.in_id_mode);
         end else begin
            want = awaited_responses.pop_front();
            if (want !== got) begin
               failures++;
               if (failures <= SHOWN_FAILURES)
                  $display("response %0d mismatch: expected data %02h step %0d id %0b, %s",
                           responses_seen, want.read_data, want.command_step, want.in_id_mode,
                           $sformatf("got data %02h step %0d id %0b",
                                     got.read_data, got.command_step, got.in_id_mode));
            end
         end
      end
   end

   initial begin
      #30000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      reset             <= 1'b1;
      csr_write_enable  <= 1'b0;
      csr_write_data    <= 1'b0;
      req_ch.valid      <= 1'b0;
      req_ch.req_type   <= 1'b0;
      req_ch.offset     <= '0;
      req_ch.write_data <= '0;
      fill_erased(0, STORE_BYTES);
      clear_sequence_state();
      flash_on = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_plain_access();
      test_id_mode();
      test_program();
      test_broken_sequence();
      test_erase();
      test_random_traffic();

      drain_responses();
      repeat (8) @(posedge clock);
      if (awaited_responses.size() != 0) begin
         failures += awaited_responses.size();
         $display("%0d responses never arrived", awaited_responses.size());
      end
      if (failures == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* filelist.f */
rtl/fbc_pkg.sv
rtl/fbc_if.sv
rtl/fbc_ctrl.sv
rtl/fbc_dpath.sv
rtl/flash_backup_command_controller.sv
verif/flash_backup_command_controller_tb.sv
